// ===== rtl/core/soa_pkg.sv =====
// Package for the slab object allocator: payload structs, size-class tables,
// status and operation codes. No dependencies.
package soa_pkg;

   localparam int CLASS_COUNT = 9;
   localparam int FRAME_NUM_W = 12;
   localparam logic [11:0] HEADER_BYTES = 12'd48;
   localparam logic [15:0] USABLE_BYTES = 16'd4048;
   localparam logic [7:0] NO_SLOT = 8'hFF;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_REALLOC = 2'd2;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BAD_SIZE    = 3'd1;
   localparam logic [2:0] ST_NO_MEMORY   = 3'd2;
   localparam logic [2:0] ST_BAD_POINTER = 3'd3;
   localparam logic [2:0] ST_NULL_FREE   = 3'd4;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] size;
      logic [63:0] address;
      logic        frame_offered;
      logic [7:0]  offered_frame;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] result_address;
      logic        frame_taken;
      logic        frame_released;
      logic [7:0]  released_frame;
      logic [31:0] live_bytes;
      logic [8:0]  live_pages;
      logic [31:0] alloc_total;
      logic [31:0] free_total;
   } rsp_type;

   // Classified request as it waits between front and back
   typedef struct packed {
      logic [1:0]             op;
      logic [15:0]            size;
      logic [63:0]            address;
      logic                   addr_null;
      logic                   size_bad;
      logic [3:0]             cls;
      logic [FRAME_NUM_W-1:0] frame_num;
      logic                   frame_ok;
      logic                   within_ok;
      logic [11:0]            body_off;
      logic                   frame_offered;
      logic [7:0]             offered_frame;
   } cmd_type;

   function automatic logic [3:0] cls_clamp(input logic [3:0] cls);
      return (cls > 4'd8) ? 4'd8 : cls;
   endfunction

   function automatic logic [11:0] class_size(input logic [3:0] cls);
      logic [11:0] sz;
      unique case (cls)
         4'd0:    sz = 12'd16;
         4'd1:    sz = 12'd32;
         4'd2:    sz = 12'd64;
         4'd3:    sz = 12'd128;
         4'd4:    sz = 12'd256;
         4'd5:    sz = 12'd512;
         4'd6:    sz = 12'd1024;
         4'd7:    sz = 12'd2048;
         default: sz = 12'd4048;
      endcase
      return sz;
   endfunction

   function automatic logic [7:0] class_slots(input logic [3:0] cls);
      logic [7:0] n;
      unique case (cls)
         4'd0:    n = 8'd253;
         4'd1:    n = 8'd126;
         4'd2:    n = 8'd63;
         4'd3:    n = 8'd31;
         4'd4:    n = 8'd15;
         4'd5:    n = 8'd7;
         4'd6:    n = 8'd3;
         default: n = 8'd1;
      endcase
      return n;
   endfunction

   function automatic logic [3:0] size_class(input logic [15:0] size);
      logic [3:0] c;
      c = 4'd8;
      for (int i = 7; i >= 0; i--) begin
         if (size <= {4'd0, class_size(4'(i))}) c = 4'(i);
      end
      return c;
   endfunction

   // Slot index from distance past the header; the largest class has one slot
   function automatic logic [7:0] slot_of(input logic [3:0] cls, input logic [11:0] d);
      logic [11:0] s;
      s = '0;
      if (cls < 4'd8) s = d >> (cls + 4'd4);
      return s[7:0];
   endfunction

   function automatic logic slot_aligned(input logic [3:0] cls, input logic [11:0] d);
      logic ok;
      if (cls < 4'd8) ok = ((d & (class_size(cls) - 12'd1)) == 12'd0);
      else ok = (d == 12'd0);
      return ok;
   endfunction

endpackage

// ===== rtl/core/soa_front.sv =====
// Front end of the slab object allocator: takes requests, sizes them into
// a class and pre-decodes the object address. Depends on soa_pkg.
module soa_front #(
   parameter int PAGE_COUNT = 256
) (
   input  logic             req_valid,
   output logic             req_ready,
   input  soa_pkg::req_type req_data,
   input  logic [63:0]      window_base,
   input  logic             q_full,
   output logic             q_push,
   output soa_pkg::cmd_type cmd
);
   import soa_pkg::*;

   logic [63:0] offset;

   assign offset    = req_data.address - window_base;
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      cmd.op            = req_data.op;
      cmd.size          = req_data.size;
      cmd.address       = req_data.address;
      cmd.addr_null     = (req_data.address == 64'd0);
      cmd.size_bad      = (req_data.size == 16'd0) || (req_data.size > USABLE_BYTES);
      cmd.cls           = size_class(req_data.size);
      cmd.frame_num     = offset[23:12];
      cmd.frame_ok      = (offset[63:12] < 52'(PAGE_COUNT));
      cmd.within_ok     = (offset[11:0] >= HEADER_BYTES);
      cmd.body_off      = offset[11:0] - HEADER_BYTES;
      cmd.frame_offered = req_data.frame_offered;
      cmd.offered_frame = req_data.offered_frame;
   end

endmodule

// ===== rtl/core/soa_queue.sv =====
// Two-entry queue of classified requests between front and back end.
// Depends on soa_pkg.
module soa_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  soa_pkg::cmd_type push_data,
   output logic             full,
   output logic             pop_valid,
   input  logic             pop,
   output soa_pkg::cmd_type pop_data
);
   import soa_pkg::*;

   cmd_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== rtl/core/soa_back.sv =====
// Back end of the slab object allocator: frame records, object links, the
// partial lists and counters, run by one sequencer. Depends on soa_pkg.
module soa_back #(
   parameter int PAGE_COUNT = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [63:0]      window_base,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   input  soa_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output soa_pkg::rsp_type rsp_data
);
   import soa_pkg::*;

   localparam int FW = $clog2(PAGE_COUNT);
   localparam int LW = $clog2(PAGE_COUNT + 1);
   localparam logic [LW-1:0] NULL_LINK = LW'(PAGE_COUNT);

   typedef struct packed {
      logic          valid;
      logic [3:0]    cls;
      logic [7:0]    free;
      logic [7:0]    total;
      logic [7:0]    head;
      logic [LW-1:0] prev;
      logic [LW-1:0] next;
   } rec_type;

   typedef enum logic [19:0] {
      S_CLEAR    = 20'h00001,
      S_IDLE     = 20'h00002,
      S_DEC      = 20'h00004,
      S_A_HEAD   = 20'h00008,
      S_A_OFR    = 20'h00010,
      S_A_FMT    = 20'h00020,
      S_A_POPRD  = 20'h00040,
      S_A_POPLK  = 20'h00080,
      S_A_POP    = 20'h00100,
      S_A_WR     = 20'h00200,
      S_F_RD     = 20'h00400,
      S_F_UPD    = 20'h00800,
      S_F_CHK    = 20'h01000,
      S_F_WR     = 20'h02000,
      S_PS0      = 20'h04000,
      S_PS1      = 20'h08000,
      S_RM0      = 20'h10000,
      S_RM1      = 20'h20000,
      S_RM2      = 20'h40000,
      S_RESP     = 20'h80000
   } state_type;

   rec_type       rec_mem [PAGE_COUNT];
   logic [7:0]    lnk_mem [PAGE_COUNT*256];

   state_type     state_ff, state_in, ret_ff, ret_in;
   cmd_type       cmd_ff, cmd_in;
   rec_type       wrec_ff, wrec_in, rec_rdata_ff, rec_wdata;
   logic [7:0]    lnk_rdata_ff, lnk_wdata;
   logic [FW-1:0] wf_ff, wf_in, oldf_ff, oldf_in, rec_raddr, rec_waddr, clr_ff, clr_in;
   logic [FW+7:0] lnk_raddr, lnk_waddr;
   logic          rec_we, lnk_we;
   logic [7:0]    idx_ff, idx_in, slot_ff, slot_in;
   logic          pend_ff, pend_in;
   logic [LW-1:0] cph_ff [CLASS_COUNT];
   logic [LW-1:0] cph_in [CLASS_COUNT];
   logic [2:0]    status_ff, status_in;
   logic [63:0]   raddr_ff, raddr_in;
   logic          taken_ff, taken_in, rel_ff, rel_in;
   logic [7:0]    rframe_ff, rframe_in;
   logic [31:0]   bytes_ff, bytes_in, allocs_ff, allocs_in, frees_ff, frees_in;
   logic [8:0]    pages_ff, pages_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic [3:0]    c_cls, w_cls, d_cls;
   logic [LW-1:0] c_head, w_head;
   logic [7:0]    d_slot, pop_free;
   logic          d_ok, ofr_ok;
   logic [19:0]   pop_off;
   logic [63:0]   pop_addr;

   assign c_cls    = cmd_ff.cls;
   assign w_cls    = cls_clamp(wrec_ff.cls);
   assign d_cls    = cls_clamp(rec_rdata_ff.cls);
   assign c_head   = cph_ff[c_cls];
   assign w_head   = cph_ff[w_cls];
   assign d_slot   = slot_of(d_cls, cmd_ff.body_off);
   assign d_ok     = cmd_ff.frame_ok && rec_rdata_ff.valid && cmd_ff.within_ok &&
                     slot_aligned(d_cls, cmd_ff.body_off) && (d_slot < rec_rdata_ff.total);
   assign ofr_ok   = cmd_ff.frame_offered && (13'(cmd_ff.offered_frame) < 13'(PAGE_COUNT));
   assign pop_free = wrec_ff.free - 8'd1;
   assign pop_off  = {12'd0, wrec_ff.head} * {8'd0, class_size(w_cls)};
   assign pop_addr = window_base + 64'({wf_ff, 12'd0}) + 64'(HEADER_BYTES) + 64'(pop_off);

   assign cmd_pop   = cmd_valid && (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;   ret_in = ret_ff;     cmd_in = cmd_ff;
      wrec_in = wrec_ff;     wf_in = wf_ff;       oldf_in = oldf_ff;
      clr_in = clr_ff;       idx_in = idx_ff;     slot_in = slot_ff;
      pend_in = pend_ff;     cph_in = cph_ff;
      status_in = status_ff; raddr_in = raddr_ff; taken_in = taken_ff;
      rel_in = rel_ff;       rframe_in = rframe_ff;
      bytes_in = bytes_ff;   allocs_in = allocs_ff; frees_in = frees_ff;
      pages_in = pages_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      rec_we = 1'b0;         rec_waddr = wf_ff;   rec_wdata = wrec_ff;
      rec_raddr = wf_ff;
      lnk_we = 1'b0;         lnk_waddr = {wf_ff, idx_ff};
      lnk_wdata = (idx_ff == 8'd0) ? NO_SLOT : idx_ff - 8'd1;
      lnk_raddr = {wf_ff, wrec_ff.head};

      unique case (state_ff)
         S_CLEAR: begin
            rec_we = 1'b1;
            rec_waddr = clr_ff;
            rec_wdata = '0;
            clr_in = clr_ff + FW'(1);
            if (clr_ff == FW'(PAGE_COUNT - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            rec_raddr = cmd.frame_num[FW-1:0];
            if (cmd_valid) begin
               cmd_in = cmd;
               pend_in = 1'b0;
               status_in = ST_OK;
               raddr_in = '0;
               taken_in = 1'b0;
               rel_in = 1'b0;
               rframe_in = '0;
               case (cmd.op)
                  OP_ALLOC: begin
                     if (cmd.size_bad) begin
                        status_in = ST_BAD_SIZE;
                        state_in = S_RESP;
                     end else state_in = S_A_HEAD;
                  end
                  OP_FREE: begin
                     if (cmd.addr_null) begin
                        status_in = ST_NULL_FREE;
                        state_in = S_RESP;
                     end else state_in = S_DEC;
                  end
                  OP_REALLOC: begin
                     if (!cmd.addr_null) state_in = S_DEC;
                     else if (cmd.size_bad) begin
                        status_in = ST_BAD_SIZE;
                        state_in = S_RESP;
                     end else state_in = S_A_HEAD;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_DEC: begin
            oldf_in = cmd_ff.frame_num[FW-1:0];
            wf_in = cmd_ff.frame_num[FW-1:0];
            slot_in = d_slot;
            if (!d_ok) begin
               status_in = ST_BAD_POINTER;
               state_in = S_RESP;
            end else if (cmd_ff.op == OP_FREE || cmd_ff.size == 16'd0) begin
               state_in = S_F_RD;
            end else if (cmd_ff.size <= {4'd0, class_size(d_cls)}) begin
               raddr_in = cmd_ff.address;
               state_in = S_RESP;
            end else if (cmd_ff.size_bad) begin
               status_in = ST_BAD_SIZE;
               state_in = S_RESP;
            end else begin
               pend_in = 1'b1;
               state_in = S_A_HEAD;
            end
         end
         S_A_HEAD: begin
            if (c_head != NULL_LINK) begin
               wf_in = c_head[FW-1:0];
               rec_raddr = c_head[FW-1:0];
               state_in = S_A_POPRD;
            end else if (ofr_ok) begin
               rec_raddr = FW'(cmd_ff.offered_frame);
               state_in = S_A_OFR;
            end else begin
               status_in = ST_NO_MEMORY;
               state_in = S_RESP;
            end
         end
         S_A_OFR: begin
            if (rec_rdata_ff.valid) begin
               status_in = ST_NO_MEMORY;
               state_in = S_RESP;
            end else begin
               wf_in = FW'(cmd_ff.offered_frame);
               wrec_in.valid = 1'b1;
               wrec_in.cls = c_cls;
               wrec_in.free = class_slots(c_cls);
               wrec_in.total = class_slots(c_cls);
               wrec_in.head = class_slots(c_cls) - 8'd1;
               wrec_in.prev = NULL_LINK;
               wrec_in.next = NULL_LINK;
               cph_in[c_cls] = LW'(cmd_ff.offered_frame);
               pages_in = pages_ff + 9'd1;
               taken_in = 1'b1;
               idx_in = 8'd0;
               state_in = S_A_FMT;
            end
         end
         S_A_FMT: begin
            // build the LIFO free list one link a cycle
            lnk_we = 1'b1;
            idx_in = idx_ff + 8'd1;
            if (idx_ff == wrec_ff.total - 8'd1) state_in = S_A_POPLK;
         end
         S_A_POPRD: begin
            wrec_in = rec_rdata_ff;
            state_in = S_A_POPLK;
         end
         S_A_POPLK: state_in = S_A_POP;
         S_A_POP: begin
            wrec_in.head = lnk_rdata_ff;
            wrec_in.free = pop_free;
            bytes_in = bytes_ff + 32'(class_size(c_cls));
            allocs_in = allocs_ff + 32'd1;
            raddr_in = pop_addr;
            if (pop_free == 8'd0) begin
               ret_in = S_A_WR;
               state_in = S_RM0;
            end else state_in = S_A_WR;
         end
         S_A_WR: begin
            rec_we = 1'b1;
            if (pend_ff) begin
               pend_in = 1'b0;
               wf_in = oldf_ff;
               state_in = S_F_RD;
            end else state_in = S_RESP;
         end
         S_F_RD: state_in = S_F_UPD;
         S_F_UPD: begin
            wrec_in = rec_rdata_ff;
            wrec_in.head = slot_ff;
            wrec_in.free = rec_rdata_ff.free + 8'd1;
            lnk_we = 1'b1;
            lnk_waddr = {wf_ff, slot_ff};
            lnk_wdata = rec_rdata_ff.head;
            bytes_in = bytes_ff - 32'(class_size(d_cls));
            frees_in = frees_ff + 32'd1;
            if (rec_rdata_ff.free == 8'd0) begin
               ret_in = S_F_CHK;
               state_in = S_PS0;
            end else state_in = S_F_CHK;
         end
         S_F_CHK: begin
            if (wrec_ff.free >= wrec_ff.total) begin
               wrec_in.valid = 1'b0;
               pages_in = pages_ff - 9'd1;
               rel_in = 1'b1;
               rframe_in = 8'(wf_ff);
               ret_in = S_F_WR;
               state_in = S_RM0;
            end else state_in = S_F_WR;
         end
         S_F_WR: begin
            rec_we = 1'b1;
            state_in = S_RESP;
         end
         S_PS0: begin
            wrec_in.next = w_head;
            wrec_in.prev = NULL_LINK;
            cph_in[w_cls] = LW'(wf_ff);
            if (w_head != NULL_LINK) begin
               rec_raddr = w_head[FW-1:0];
               state_in = S_PS1;
            end else state_in = ret_ff;
         end
         S_PS1: begin
            rec_we = 1'b1;
            rec_waddr = wrec_ff.next[FW-1:0];
            rec_wdata = rec_rdata_ff;
            rec_wdata.prev = LW'(wf_ff);
            state_in = ret_ff;
         end
         S_RM0: begin
            if (wrec_ff.prev == NULL_LINK) cph_in[w_cls] = wrec_ff.next;
            else rec_raddr = wrec_ff.prev[FW-1:0];
            state_in = S_RM1;
         end
         S_RM1: begin
            if (wrec_ff.prev != NULL_LINK) begin
               rec_we = 1'b1;
               rec_waddr = wrec_ff.prev[FW-1:0];
               rec_wdata = rec_rdata_ff;
               rec_wdata.next = wrec_ff.next;
            end
            if (wrec_ff.next != NULL_LINK) begin
               rec_raddr = wrec_ff.next[FW-1:0];
               state_in = S_RM2;
            end else begin
               wrec_in.prev = NULL_LINK;
               wrec_in.next = NULL_LINK;
               state_in = ret_ff;
            end
         end
         S_RM2: begin
            rec_we = 1'b1;
            rec_waddr = wrec_ff.next[FW-1:0];
            rec_wdata = rec_rdata_ff;
            rec_wdata.prev = wrec_ff.prev;
            wrec_in.prev = NULL_LINK;
            wrec_in.next = NULL_LINK;
            state_in = ret_ff;
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = status_ff;
               rsp_in.result_address = raddr_ff;
               rsp_in.frame_taken = taken_ff;
               rsp_in.frame_released = rel_ff;
               rsp_in.released_frame = rframe_ff;
               rsp_in.live_bytes = bytes_ff;
               rsp_in.live_pages = pages_ff;
               rsp_in.alloc_total = allocs_ff;
               rsp_in.free_total = frees_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rec_we) rec_mem[rec_waddr] <= rec_wdata;
      rec_rdata_ff <= rec_mem[rec_raddr];
      if (lnk_we) lnk_mem[lnk_waddr] <= lnk_wdata;
      lnk_rdata_ff <= lnk_mem[lnk_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ret_ff <= S_IDLE;
         clr_ff <= '0;
         pend_ff <= 1'b0;
         for (int i = 0; i < CLASS_COUNT; i++) cph_ff[i] <= NULL_LINK;
         bytes_ff <= '0;
         allocs_ff <= '0;
         frees_ff <= '0;
         pages_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         clr_ff <= clr_in;
         pend_ff <= pend_in;
         cph_ff <= cph_in;
         bytes_ff <= bytes_in;
         allocs_ff <= allocs_in;
         frees_ff <= frees_in;
         pages_ff <= pages_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      wrec_ff <= wrec_in;
      wf_ff <= wf_in;
      oldf_ff <= oldf_in;
      idx_ff <= idx_in;
      slot_ff <= slot_in;
      status_ff <= status_in;
      raddr_ff <= raddr_in;
      taken_ff <= taken_in;
      rel_ff <= rel_in;
      rframe_ff <= rframe_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ===== rtl/core/slab_object_allocator_top.sv =====
// Slab object allocator top level: configuration register, front end, queue
// and back end. Depends on soa_pkg, soa_front, soa_queue and soa_back.
//
// Requests (allocate, free, reallocate) arrive on req_valid/req_ready with a
// req_type payload; each gives exactly one result on rsp_valid/rsp_ready.
// The front end classifies a request in the cycle of its transfer and parks
// it in a two-entry queue, so requests are taken while the back end works.
// The back end handles one request at a time through frame record and object
// link memories, each with one read and one write port: an allocate from a
// partial slab or a free updates its frame record, plus the states S_PS0 and
// S_PS1 or S_RM0 to S_RM2 each time a slab goes onto or off its partial list;
// a new slab first builds its free list over every object slot (1 to 253). A
// reallocate that moves adds a free. Rejected requests write no memory.
// After reset every frame record is cleared before the first request is
// served; window_base may be written meanwhile. A stalled receiver leaves
// the result in the output register; the back end then waits with the next
// result and the queue fills before req_ready drops.
module slab_object_allocator_top #(
   parameter int PAGE_COUNT = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  soa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output soa_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [63:0]      csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);
   import soa_pkg::*;

   logic [63:0] window_base_ff, window_base_in;
   logic        q_full, q_push, q_valid, q_pop;
   cmd_type     q_wdata, q_rdata;

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[3] ? 64'd0 : window_base_ff;

   always_comb begin
      window_base_in = window_base_ff;
      if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[3]) window_base_in = csr_pwdata;
   end

   always_ff @(posedge clock) begin
      if (reset) window_base_ff <= '0;
      else window_base_ff <= window_base_in;
   end

   soa_front #(.PAGE_COUNT(PAGE_COUNT)) u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .window_base (window_base_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .cmd         (q_wdata)
   );

   soa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop       (q_pop),
      .pop_data  (q_rdata)
   );

   soa_back #(.PAGE_COUNT(PAGE_COUNT)) u_back (
      .clock       (clock),
      .reset       (reset),
      .window_base (window_base_ff),
      .cmd_valid   (q_valid),
      .cmd_pop     (q_pop),
      .cmd         (q_rdata),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== dv/tb_slab_object_allocator_top.sv =====
// Testbench for slab_object_allocator_top: drives requests and window_base writes,
// predicts every result with its own slab model and checks them in order.
// Depends on soa_pkg and the RTL of the allocator.
`timescale 1ns / 1ps

module tb_slab_object_allocator_top;
   import soa_pkg::*;

   localparam int FRAMES = 256;
   localparam logic [3:0] REG_WINDOW_BASE = 4'd0;
   localparam int STALL_LIMIT = 4000;
   localparam logic [8:0] NULL_FRAME = 9'd256;

   class slab_scoreboard;
      logic [63:0] wbase;
      bit          fvalid[FRAMES];
      logic [3:0]  fcls[FRAMES];
      logic [7:0]  ffree[FRAMES];
      logic [7:0]  ftot[FRAMES];
      logic [7:0]  fhead[FRAMES];
      logic [8:0]  fprev[FRAMES];
      logic [8:0]  fnext[FRAMES];
      logic [7:0]  olink[65536];
      logic [8:0]  phead[9];
      logic [31:0] bytes_live, allocs, frees;
      logic [8:0]  pages;
      rsp_type     pending[$];
      int          errors;

      function new();
         wbase = '0;
         for (int i = 0; i < FRAMES; i++) begin
            fvalid[i] = 0;
            fprev[i] = NULL_FRAME;
            fnext[i] = NULL_FRAME;
         end
         for (int c = 0; c < 9; c++) phead[c] = NULL_FRAME;
         bytes_live = '0; allocs = '0; frees = '0; pages = '0;
         errors = 0;
      endfunction

      function int unsigned csize(logic [3:0] c);
         return (c < 8) ? (16 << c) : 4048;
      endfunction

      function void push(int c, int f);
         logic [8:0] h;
         h = phead[c];
         fnext[f] = h;
         if (h < NULL_FRAME) fprev[h] = 9'(f);
         fprev[f] = NULL_FRAME;
         phead[c] = 9'(f);
      endfunction

      function void unlink(int c, int f);
         logic [8:0] p, n;
         p = fprev[f];
         n = fnext[f];
         if (p < NULL_FRAME) fnext[p] = n;
         else phead[c] = n;
         if (n < NULL_FRAME) fprev[n] = p;
         fprev[f] = NULL_FRAME;
         fnext[f] = NULL_FRAME;
      endfunction

      function logic [63:0] addr_of(int f, int slot);
         return wbase + 64'(f) * 4096 + 48 + 64'(slot) * csize(fcls[f]);
      endfunction

      function logic [2:0] take(logic [15:0] size, logic offered, logic [7:0] ofr,
                                inout rsp_type r);
         int c, f, n, slot;
         c = 0;
         if (size == 0 || size > 4048) return ST_BAD_SIZE;
         while (c < 8 && size > csize(4'(c))) c++;
         f = phead[c];
         if (f >= FRAMES) begin
            if (!offered || fvalid[ofr]) return ST_NO_MEMORY;
            f = ofr;
            n = 4048 / csize(4'(c));
            fvalid[f] = 1;
            fcls[f] = 4'(c);
            // fresh slab: each slot links to the one below it
            for (int i = 0; i < n; i++) olink[f*256 + i] = (i == 0) ? 8'hFF : 8'(i - 1);
            fhead[f] = 8'(n - 1);
            ftot[f] = 8'(n);
            ffree[f] = 8'(n);
            push(c, f);
            pages++;
            r.frame_taken = 1;
         end
         slot = fhead[f];
         fhead[f] = olink[f*256 + slot];
         ffree[f]--;
         if (ffree[f] == 0) unlink(c, f);
         bytes_live += csize(4'(c));
         allocs++;
         r.result_address = addr_of(f, slot);
         return ST_OK;
      endfunction

      function bit decode(logic [63:0] a, output int f, output int slot);
         logic [63:0] off;
         int unsigned page_off, sz, d;
         off = a - wbase;
         f = 0; slot = 0;
         if ((off >> 12) >= FRAMES) return 0;
         f = int'(off >> 12);
         if (!fvalid[f]) return 0;
         page_off = 32'(off[11:0]);
         if (page_off < 48) return 0;
         sz = csize(fcls[f]);
         d = page_off - 48;
         if (d % sz != 0 || d / sz >= ftot[f]) return 0;
         slot = d / sz;
         return 1;
      endfunction

      function void release_slot(int f, int slot, inout rsp_type r);
         bit had_none_free;
         int c;
         c = fcls[f];
         had_none_free = (ffree[f] == 0);
         olink[f*256 + slot] = fhead[f];
         fhead[f] = 8'(slot);
         ffree[f]++;
         bytes_live -= csize(4'(c));
         frees++;
         if (had_none_free) push(c, f);
         if (ffree[f] >= ftot[f]) begin
            unlink(c, f);
            fvalid[f] = 0;
            pages--;
            r.frame_released = 1;
            r.released_frame = 8'(f);
         end
      endfunction

      function rsp_type note(req_type q);
         rsp_type r;
         int f, slot;
         r = '0;
         r.status = ST_OK;
         if (q.op == OP_ALLOC) begin
            r.status = take(q.size, q.frame_offered, q.offered_frame, r);
         end else if (q.op == OP_FREE) begin
            if (q.address == 0) r.status = ST_NULL_FREE;
            else if (!decode(q.address, f, slot)) r.status = ST_BAD_POINTER;
            else release_slot(f, slot, r);
         end else if (q.op == OP_REALLOC) begin
            if (q.address == 0) r.status = take(q.size, q.frame_offered, q.offered_frame, r);
            else if (!decode(q.address, f, slot)) r.status = ST_BAD_POINTER;
            else if (q.size == 0) release_slot(f, slot, r);
            else if (q.size <= csize(fcls[f])) r.result_address = q.address;
            else begin
               r.status = take(q.size, q.frame_offered, q.offered_frame, r);
               if (r.status == ST_OK) release_slot(f, slot, r);
            end
         end
         r.live_bytes = bytes_live;
         r.live_pages = pages;
         r.alloc_total = allocs;
         r.free_total = frees;
         pending.push_back(r);
         return r;
      endfunction

      function void cmp(string name, logic [63:0] e, logic [63:0] a);
         if (e !== a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            errors++;
         end
      endfunction

      function void check(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("result with nothing outstanding: %p", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         cmp("status", 64'(e.status), 64'(a.status));
         cmp("result_address", e.result_address, a.result_address);
         cmp("frame_taken", 64'(e.frame_taken), 64'(a.frame_taken));
         cmp("frame_released", 64'(e.frame_released), 64'(a.frame_released));
         cmp("released_frame", 64'(e.released_frame), 64'(a.released_frame));
         cmp("live_bytes", 64'(e.live_bytes), 64'(a.live_bytes));
         cmp("live_pages", 64'(e.live_pages), 64'(a.live_pages));
         cmp("alloc_total", 64'(e.alloc_total), 64'(a.alloc_total));
         cmp("free_total", 64'(e.free_total), 64'(a.free_total));
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   rsp_type     rsp_data;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   slab_scoreboard slabs = new();
   bit      no_gaps = 0;
   int      idle_cycles = 0;
   int      n_sent = 0, n_taken = 0, n_released = 0, n_alloc_ok = 0;
   int      live[$];    // frame*256 + slot of objects believed allocated
   int      dead[$];    // recently freed, kept for double frees

   slab_object_allocator_top uut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) slabs.check(rsp_data);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[slab_object_allocator_top] ERROR");
         $finish;
      end
   end

   // result side: random stall before each transfer
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_ready <= 0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   function automatic int key_of(logic [63:0] a);
      logic [63:0] off;
      int f;
      off = a - slabs.wbase;
      f = int'(off >> 12);
      return f * 256 + (int'(off[11:0]) - 48) / slabs.csize(slabs.fcls[f]);
   endfunction

   function automatic logic [63:0] key_addr(int k);
      return slabs.addr_of(k / 256, k % 256);
   endfunction

   // send one request, starting at a falling edge; return at the falling edge after its transfer
   task automatic send(req_type q, output rsp_type r);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= q;
      do @(posedge clock); while (!req_ready);
      r = slabs.note(q);
      n_sent++;
      if (r.frame_taken) n_taken++;
      if (r.frame_released) n_released++;
      if (r.status == ST_OK && r.result_address != 0 && r.result_address != q.address)
         n_alloc_ok++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 0;
      while (slabs.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_window_base(logic [63:0] v);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= REG_WINDOW_BASE; csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      slabs.wbase = v;
      @(negedge clock);
   endtask

   function automatic req_type mk(logic [1:0] op, logic [15:0] size, logic [63:0] a,
                                  logic offered, logic [7:0] ofr);
      req_type q;
      q.op = op; q.size = size; q.address = a;
      q.frame_offered = offered; q.offered_frame = ofr;
      return q;
   endfunction

   function automatic logic [7:0] pick_frame();
      int f;
      f = $urandom_range(0, FRAMES - 1);
      if ($urandom_range(0, 9) < 8)
         for (int i = 0; i < FRAMES && slabs.fvalid[f]; i++) f = (f + 1) % FRAMES;
      return 8'(f);
   endfunction

   function automatic logic [15:0] pick_size();
      int w;
      w = $urandom_range(0, 99);
      if (w < 65) return 16'($urandom_range(1, 256));
      if (w < 85) return 16'($urandom_range(257, 4048));
      if (w < 92) return 16'(slabs.csize(4'($urandom_range(0, 8))));
      if (w < 95) return 16'd0;
      return 16'($urandom_range(4049, 65535));
   endfunction

   task automatic random_item();
      req_type q;
      rsp_type r;
      int w, idx, k;
      bit from_live;
      w = $urandom_range(0, 99);
      if (live.size() > 350) w = 45;
      from_live = 0;
      idx = 0;
      k = 0;
      q = mk(OP_ALLOC, pick_size(), '0, $urandom_range(0, 19) != 0, pick_frame());
      if (w >= 40) begin
         q.op = (w < 72) ? OP_FREE : OP_REALLOC;
         if ($urandom_range(0, 99) < 82 && live.size() != 0) begin
            idx = $urandom_range(0, live.size() - 1);
            k = live[idx];
            q.address = key_addr(k);
            from_live = 1;
         end else begin
            case ($urandom_range(0, 3))
               0: q.address = '0;
               1: q.address = {$urandom, $urandom};
               2: if (dead.size() != 0) q.address = key_addr(dead[$urandom_range(0,
                                                             dead.size() - 1)]);
               default: q.address = slabs.wbase + 64'($urandom_range(0, 1048575));
            endcase
         end
         if (q.op == OP_REALLOC && $urandom_range(0, 4) == 0) q.size = '0;
      end
      send(q, r);
      if (r.status != ST_OK) return;
      if (from_live && (q.op == OP_FREE || r.result_address != q.address)) begin
         live.delete(idx);
         dead.push_back(k);
         if (dead.size() > 24) void'(dead.pop_front());
      end
      if (r.result_address != 0 && r.result_address != q.address)
         live.push_back(key_of(r.result_address));
   endtask

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         random_item();
      end
      no_gaps = 0;
   endtask

   initial begin
      rsp_type r;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      write_window_base(64'h0);

      // size limits and class edges
      send(mk(OP_ALLOC, 16'd0, '0, 1, 8'd0), r);
      send(mk(OP_ALLOC, 16'd4049, '0, 1, 8'd0), r);
      send(mk(OP_ALLOC, 16'hFFFF, '0, 1, 8'd0), r);
      send(mk(OP_ALLOC, 16'd1, '0, 1, 8'd0), r);
      send(mk(OP_ALLOC, 16'd16, '0, 1, 8'd9), r);
      send(mk(OP_ALLOC, 16'd17, '0, 1, 8'd255), r);
      // out of memory: nothing offered, then an occupied frame
      send(mk(OP_ALLOC, 16'd4048, '0, 0, 8'd1), r);
      send(mk(OP_ALLOC, 16'd4048, '0, 1, 8'd0), r);
      send(mk(OP_ALLOC, 16'd4048, '0, 1, 8'd1), r);
      send(mk(OP_ALLOC, 16'd2048, '0, 1, 8'd2), r);
      // bad pointers: null, header, misaligned, past last slot, outside the window
      send(mk(OP_FREE, '0, '0, 0, 8'd0), r);
      send(mk(OP_FREE, '0, 64'd16, 0, 8'd0), r);
      send(mk(OP_FREE, '0, 64'd49, 0, 8'd0), r);
      send(mk(OP_FREE, '0, 64'(2*4096 + 48 + 2048), 0, 8'd0), r);
      send(mk(OP_FREE, '0, 64'hFFFF_FFFF_FFFF_FFF0, 0, 8'd0), r);
      // reallocate: from null, keep, grow, grow without memory, bad size, to zero
      send(mk(OP_REALLOC, 16'd100, '0, 1, 8'd3), r);
      send(mk(OP_REALLOC, 16'd10, 64'(48 + 251*16), 1, 8'd3), r);
      send(mk(OP_REALLOC, 16'd3000, 64'(48 + 251*16), 1, 8'd4), r);
      send(mk(OP_REALLOC, 16'd4000, 64'(2*4096 + 48), 0, 8'd5), r);
      send(mk(OP_REALLOC, 16'd5000, 64'(2*4096 + 48), 1, 8'd5), r);
      send(mk(OP_REALLOC, 16'd0, 64'(1*4096 + 48), 1, 8'd5), r);
      // double free of the same slot, then a free in an unused frame
      send(mk(OP_FREE, '0, 64'(48 + 252*16), 0, 8'd0), r);
      send(mk(OP_FREE, '0, 64'(48 + 252*16), 0, 8'd0), r);
      send(mk(OP_FREE, '0, 64'(9*4096 + 48 + 252*16), 0, 8'd0), r);

      // seed the live list with every slot of each formatted frame, then run under four window bases
      for (int f = 0; f < FRAMES; f++)
         if (slabs.fvalid[f])
            for (int s = 0; s < slabs.ftot[f]; s++) live.push_back(f*256 + s);
      random_phase(450);
      settle();
      write_window_base(64'hFFFF_FFFF_FFFF_F000);
      random_phase(450);
      settle();
      write_window_base(64'hFFFF_FFFF_FFFF_FFFF);
      random_phase(350);
      settle();
      write_window_base({$urandom, 20'($urandom_range(0, 1048575)), 12'h000});
      random_phase(450);
      settle();

      $display("Covered %0d requests: %0d objects handed out, %0d slabs formatted,",
               n_sent, n_alloc_ok, n_taken);
      $display("%0d frames released, under four window bases.", n_released);
      if (slabs.errors == 0 && slabs.pending.size() == 0) begin
         $display("[slab_object_allocator_top] OK");
      end else begin
         $display("[slab_object_allocator_top] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/soa_pkg.sv
rtl/core/soa_front.sv
rtl/core/soa_queue.sv
rtl/core/soa_back.sv
rtl/core/slab_object_allocator_top.sv
dv/tb_slab_object_allocator_top.sv
